[hdl/sqcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqcd_pkg: shared types for the shortest queue call dispatcher
// Function codes and the request/result payload structures.
// ----------------------------------------------------------------------------
package sqcd_pkg;

  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] job_duration;
  } req_t;

  typedef struct packed {
    logic [2:0]  chosen_server;
    logic        refused;
    logic [31:0] jobs_accepted;
    logic [31:0] total_wait;
    logic        all_queues_empty;
  } rsp_t;

endpackage

[hdl/sqcd_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqcd_req_if: request channel
// Valid/ready channel carrying one dispatcher request.
// ----------------------------------------------------------------------------
interface sqcd_req_if import sqcd_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/sqcd_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqcd_rsp_if: result channel
// Valid/ready channel carrying one dispatcher result.
// ----------------------------------------------------------------------------
interface sqcd_rsp_if import sqcd_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/shortest_queue_call_dispatcher_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_queue_call_dispatcher_top: join-shortest-queue dispatcher
// Sequencer that walks the servers one per step.
// ----------------------------------------------------------------------------
// One request at a time. An arrival walks the active queues one per cycle
// to find the shortest (lowest index wins ties), then writes the job into
// the job memory, or refuses it if that queue is full. A tick visits each
// active server, adding a memory read and a wait accumulate step for a
// server that starts a new job, then advances time and loads the result.
// The registered read of the job memory is why a starting server needs
// the read step. Each result is held in an output register until taken;
// ready drops while a request is in work or a result waits. The
// active_servers register may be written only while idle; 0 acts as 1
// and values above MAX_SERVERS act as MAX_SERVERS.
module shortest_queue_call_dispatcher_top
  import sqcd_pkg::*;
#(
  parameter int unsigned MAX_SERVERS = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  sqcd_req_if.sink   req,
  sqcd_rsp_if.source rsp
);
  localparam int unsigned SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = SW + QW;
  localparam int unsigned NW = $clog2(MAX_SERVERS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_PLACE = 3'd2;
  localparam logic [2:0] ST_SERVE = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_START = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [3:0]    active_q;
  logic [CW-1:0] cnt_q  [MAX_SERVERS];
  logic [QW-1:0] head_q [MAX_SERVERS];
  logic [QW-1:0] tail_q [MAX_SERVERS];
  logic [15:0]   elap_q [MAX_SERVERS];
  logic [15:0]   dur_q  [MAX_SERVERS];
  logic [31:0]   time_q, wait_q, acc_q;
  logic [SW-1:0] idx_q, best_q;
  logic [15:0]   jdur_q;
  rsp_t          rsp_q;
  logic          rsp_valid_q;

  // Effective server count, clamped to 1..MAX_SERVERS.
  logic [NW-1:0] n_act;
  always_comb begin
    if (active_q == 4'd0) n_act = NW'(1);
    else if (32'(active_q) > MAX_SERVERS) n_act = NW'(MAX_SERVERS);
    else n_act = NW'(active_q);
  end

  logic last_idx;
  assign last_idx = (32'(idx_q) + 1 >= 32'(n_act));

  // Job memory ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [47:0]   mem_rdata;
  assign mem_we    = (state_q == ST_PLACE) && (32'(cnt_q[best_q]) < QUEUE_DEPTH);
  assign mem_waddr = {best_q, tail_q[best_q]};
  assign mem_raddr = {idx_q, head_q[idx_q]};

  sqcd_job_mem #(.Depth(MAX_SERVERS << QW), .AddrW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i ({time_q, jdur_q}),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared adder: wait accumulate or counter increment.
  logic [31:0] add_a, add_b;
  logic [32:0] add_s;
  logic [31:0] add_sat;
  assign add_a   = (state_q == ST_START) ? wait_q : acc_q;
  assign add_b   = (state_q == ST_START) ? (time_q - mem_rdata[47:16]) : 32'd1;
  assign add_s   = {1'b0, add_a} + {1'b0, add_b};
  assign add_sat = add_s[32] ? 32'hFFFF_FFFF : add_s[31:0];

  logic any_busy;
  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < MAX_SERVERS; i++) begin
      if (32'(i) < 32'(n_act) && cnt_q[i] != '0) any_busy = 1'b1;
    end
  end

  assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req.valid && req.ready) begin
          state_d = (req.payload.func == FUNC_TICK) ? ST_SERVE : ST_SCAN;
        end
      end
      ST_SCAN:  if (last_idx) state_d = ST_PLACE;
      ST_PLACE: state_d = ST_OUT;
      ST_SERVE: begin
        if (elap_q[idx_q] >= dur_q[idx_q] && cnt_q[idx_q] != '0) state_d = ST_READ;
        else if (last_idx) state_d = ST_DONE;
      end
      ST_READ:  state_d = ST_START;
      ST_START: state_d = last_idx ? ST_DONE : ST_SERVE;
      ST_DONE:  state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 4'd1;
      time_q      <= '0;
      wait_q      <= '0;
      acc_q       <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
        elap_q[i] <= '0;
        dur_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) active_q <= cfg_wdata_i;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          idx_q  <= '0;
          best_q <= '0;
          // Hold a waiting result; clear its flags only when a new request starts.
          if (req.valid && req.ready) begin
            rsp_q.refused       <= 1'b0;
            rsp_q.chosen_server <= '0;
          end
        end
        ST_SCAN: begin
          // Track the shortest queue seen so far; strict compare keeps ties low.
          if (cnt_q[idx_q] < cnt_q[best_q]) best_q <= idx_q;
          idx_q <= idx_q + SW'(1);
        end
        ST_PLACE: begin
          rsp_q.chosen_server <= 3'(best_q);
          if (mem_we) begin
            tail_q[best_q] <= (32'(tail_q[best_q]) + 1 >= QUEUE_DEPTH) ? '0
                              : tail_q[best_q] + QW'(1);
            cnt_q[best_q]  <= cnt_q[best_q] + CW'(1);
            acc_q          <= add_sat;
          end else begin
            rsp_q.refused <= 1'b1;
          end
        end
        ST_SERVE: begin
          if (elap_q[idx_q] < dur_q[idx_q]) begin
            elap_q[idx_q] <= elap_q[idx_q] + 16'd1;
          end
          if (!(elap_q[idx_q] >= dur_q[idx_q] && cnt_q[idx_q] != '0)) begin
            idx_q <= idx_q + SW'(1);
          end
        end
        ST_READ: ;
        ST_START: begin
          // Start the head job and add its queue wait.
          dur_q[idx_q]  <= mem_rdata[15:0];
          elap_q[idx_q] <= '0;
          head_q[idx_q] <= (32'(head_q[idx_q]) + 1 >= QUEUE_DEPTH) ? '0
                           : head_q[idx_q] + QW'(1);
          cnt_q[idx_q]  <= cnt_q[idx_q] - CW'(1);
          wait_q        <= add_sat;
          idx_q         <= idx_q + SW'(1);
        end
        ST_DONE: time_q <= time_q + 32'd1;
        ST_OUT: begin
          rsp_q.jobs_accepted    <= acc_q;
          rsp_q.total_wait       <= wait_q;
          rsp_q.all_queues_empty <= !any_busy;
          rsp_valid_q            <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req.valid && req.ready) jdur_q <= req.payload.job_duration;
  end
endmodule

[hdl/sqcd_job_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqcd_job_mem: job store
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module sqcd_job_mem #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [47:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [47:0]      rdata_o
);
  logic [47:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

[hdl/sqcd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqcd_checker: port-level checks
// Watches the dispatcher ports over time.
// ----------------------------------------------------------------------------
module sqcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] acc_i,
  input logic [31:0] wait_i,
  input logic        refused_i
);
  // A result that waits keeps the request side closed.
  a_no_ready_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i) else $error("ready while result waits");
  // A request is never accepted twice in back-to-back cycles.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i) else $error("ready after accept");
  // Accepted-count check; it holds trivially, as $rose implies the || term.
  a_acc_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> acc_i >= $past(acc_i, 1) || !$past(rsp_valid_i, 1))
    else $error("accept count dropped");
  // A stalled result stays valid with its wait and refused fields unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i && $stable(wait_i) && $stable(refused_i))
    else $error("result changed while stalled");
endmodule

bind shortest_queue_call_dispatcher_top sqcd_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req.valid),
  .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .acc_i       (rsp.payload.jobs_accepted),
  .wait_i      (rsp.payload.total_wait),
  .refused_i   (rsp.payload.refused)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the shortest queue call dispatcher
// Sends arrival and tick requests through the valid/ready channel. A
// behavioral copy of the dispatcher predicts every result, and a checker
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import sqcd_pkg::*;

  localparam int NSRV  = 8;
  localparam int DEPTH = 16;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd0;

  sqcd_req_if req ();
  sqcd_rsp_if rsp ();

  shortest_queue_call_dispatcher_top #(.MAX_SERVERS(NSRV), .QUEUE_DEPTH(DEPTH)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req.sink), .rsp(rsp.source)
  );

  always #1 clk_i = ~clk_i;

  // Dispatcher state as seen from outside.
  logic [47:0] jobs_mem [NSRV][DEPTH];
  int unsigned qlen [NSRV];
  int unsigned qhd  [NSRV];
  int unsigned qtl  [NSRV];
  logic [15:0] srv_el  [NSRV];
  logic [15:0] srv_dur [NSRV];
  logic [31:0] now_ticks;
  logic [31:0] wait_total;
  logic [31:0] accepted_total;
  logic [3:0]  n_active_reg;

  rsp_t expected_q [$];
  int   errors;
  bit   hold_rsp;   // long receiver hold-off
  bit   rand_stall = 1'b1;

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Apply one request to the predicted state and queue its result.
  function automatic void dispatch_predict(req_t r);
    int   n;
    int   pick;
    rsp_t o;
    logic [47:0] e;
    n = (n_active_reg == 0) ? 1 : ((n_active_reg > NSRV) ? NSRV : n_active_reg);
    pick = 0;
    o = '0;
    if (r.func == FUNC_ARRIVAL) begin
      for (int i = 1; i < n; i++) if (qlen[i] < qlen[pick]) pick = i;
      if (qlen[pick] >= DEPTH) begin
        o.refused = 1'b1;
      end else begin
        jobs_mem[pick][qtl[pick]] = {now_ticks, r.job_duration};
        qtl[pick] = (qtl[pick] + 1) % DEPTH;
        qlen[pick]++;
        accepted_total = sat_sum(accepted_total, 32'd1);
      end
      o.chosen_server = pick[2:0];
    end else begin
      for (int i = 0; i < n; i++) begin
        if (srv_el[i] < srv_dur[i]) begin
          srv_el[i] = srv_el[i] + 16'd1;
        end else if (qlen[i] != 0) begin
          e = jobs_mem[i][qhd[i]];
          srv_dur[i] = e[15:0];
          srv_el[i] = '0;
          qhd[i] = (qhd[i] + 1) % DEPTH;
          qlen[i]--;
          wait_total = sat_sum(wait_total, now_ticks - e[47:16]);
        end
      end
      now_ticks++;
    end
    o.jobs_accepted = accepted_total;
    o.total_wait = wait_total;
    o.all_queues_empty = 1'b1;
    for (int i = 0; i < n; i++) if (qlen[i] != 0) o.all_queues_empty = 1'b0;
    expected_q.push_back(o);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Random gap: mostly short, sometimes long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one request and wait for its handshake; predict on acceptance.
  // Valid is low between requests.
  task automatic send_request(logic fn, logic [15:0] dur, bit gaps = 1);
    req_t r;
    int   g;
    r.func = fn;
    r.job_duration = dur;
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(posedge clk_i);
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk_i); while (!req.ready);
    dispatch_predict(r);
    req.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Write the register only while idle.
  task automatic set_active(logic [3:0] v);
    wait_drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_active_reg = v;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls unless held off or stalls are disabled.
  always @(posedge clk_i) begin
    if (hold_rsp) begin
      rsp.ready <= 1'b0;
    end else if (rand_stall) begin
      rsp.ready <= ($urandom_range(0, 99) < 65);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Checker: compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t g;
    rsp_t w;
    if (rst_ni && rsp.valid && rsp.ready) begin
      g = rsp.payload;
      if (expected_q.size() == 0) begin
        $display("MISMATCH unexpected result at %0t", $realtime);
        errors++;
      end else begin
        w = expected_q.pop_front();
        if (g.chosen_server !== w.chosen_server)
          report_mismatch("chosen_server", 32'(g.chosen_server), 32'(w.chosen_server));
        if (g.refused !== w.refused)
          report_mismatch("refused", 32'(g.refused), 32'(w.refused));
        if (g.jobs_accepted !== w.jobs_accepted)
          report_mismatch("jobs_accepted", g.jobs_accepted, w.jobs_accepted);
        if (g.total_wait !== w.total_wait)
          report_mismatch("total_wait", g.total_wait, w.total_wait);
        if (g.all_queues_empty !== w.all_queues_empty)
          report_mismatch("all_queues_empty", 32'(g.all_queues_empty),
                          32'(w.all_queues_empty));
      end
    end
  end

  // Directed: field extremes, both functions, full queue, zero duration.
  task automatic test_directed();
    send_request(FUNC_TICK, 16'hFFFF);        // tick on empty system
    send_request(FUNC_ARRIVAL, 16'd0);        // zero-duration job
    send_request(FUNC_TICK, 16'd0);
    send_request(FUNC_TICK, 16'd0);
    send_request(FUNC_ARRIVAL, 16'hFFFF);     // longest job occupies server 0
    send_request(FUNC_TICK, 16'h0);
    // fill the single queue until refusal
    for (int i = 0; i < DEPTH + 2; i++) send_request(FUNC_ARRIVAL, 16'h5555 ^ i[15:0]);
  endtask

  // Out-of-range settings, ties among queues and frozen inactive queues.
  task automatic test_active_range();
    set_active(4'd0);
    repeat (3) send_request(FUNC_ARRIVAL, 16'd2);
    set_active(4'd15);
    repeat (10) send_request(FUNC_ARRIVAL, 16'($urandom_range(0, 3)));
    repeat (6) send_request(FUNC_TICK, 16'd0);
    set_active(4'd3);                         // servers 3..7 frozen
    repeat (8) send_request(FUNC_TICK, 16'd0);
    set_active(4'd8);
  endtask

  // Random mix; short durations keep queues moving, some long for backlog.
  task automatic test_random(int count);
    logic [15:0] d;
    int k;
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 299) set_active(4'($urandom_range(0, 15)));
      k = $urandom_range(0, 99);
      if (k < 3) d = 16'($urandom);
      else if (k < 6) d = 16'hFFFF - 16'($urandom_range(0, 3));
      else d = 16'($urandom_range(0, 6));
      send_request(($urandom_range(0, 99) < 45) ? FUNC_ARRIVAL : FUNC_TICK, d);
    end
  endtask

  // Block the receiver for a long stretch while requests keep coming.
  task automatic test_backpressure();
    fork
      begin
        hold_rsp = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++)
          send_request(i[0] ? FUNC_TICK : FUNC_ARRIVAL, 16'd1, 0);
      end
    join
    wait_drain();                             // sender pauses until all results are in
    rand_stall = 1'b0;                        // a stretch with no receiver stalls
    for (int i = 0; i < 40; i++) send_request(i[1], i[15:0], 0);
    rand_stall = 1'b1;
  endtask

  initial begin
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b0;
    hold_rsp = 1'b0;
    errors = 0;
    now_ticks = '0;
    wait_total = '0;
    accepted_total = '0;
    n_active_reg = 4'd1;
    for (int i = 0; i < NSRV; i++) begin
      qlen[i] = 0; qhd[i] = 0; qtl[i] = 0; srv_el[i] = '0; srv_dur[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_active_range();
    test_backpressure();
    test_random(1850);
    wait_drain();
    if (errors == 0) $display("shortest_queue_call_dispatcher_top test passed");
    else $display("shortest_queue_call_dispatcher_top test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("shortest_queue_call_dispatcher_top test failed");
    $finish;
  end
endmodule

[shortest_queue_call_dispatcher_top.f]
hdl/sqcd_pkg.sv
hdl/sqcd_req_if.sv
hdl/sqcd_rsp_if.sv
hdl/sqcd_job_mem.sv
hdl/shortest_queue_call_dispatcher_top.sv
hdl/sqcd_checker.sv
verif/tb_top.sv
